// ===== rtl/assert_macros.svh =====
// Shared assertion helpers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent check on clk, switched off while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same check, also evaluated while in reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/wdpc_pkg.sv =====
package wdpc_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int CW  = 34;   // CORDIC datapath width, Q30 plus headroom
  localparam int D_W = 18;   // reading in Q10.8 inches, unsigned
  localparam int V_W = 24;   // projected coordinate, Q16.8 signed

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [19:0] MM_TO_IN = 20'd660521;
  localparam logic [13:0] INVALID_READING = 14'd9999;

  typedef enum logic [2:0] {
    CFG_WALL   = 3'd0,
    CFG_WINDOW = 3'd1,
    CFG_OFFX   = 3'd2,
    CFG_OFFY   = 3'd3,
    CFG_ANGLE  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
  } rot_t;

  typedef struct packed {
    logic               vld;
    logic               rvalid;
    logic [D_W-1:0]     d;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               use_x;
    logic               forced;
  } item_t;

  function automatic logic [31:0] cordic_atan(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/wall_distance_pose_correction_core.sv =====
// Channel  | ports                                   | handshake
// in       | in_distance_mm .. in_forced             | start && !busy
// out      | out_reading_valid .. out_new_y          | out_strobe, one cycle
// cfg      | cfg_we, cfg_index, cfg_data             | cfg_we, no wait
//
// One beat accepted every cycle that busy is low; busy is set in reset and cleared once rst_n is high.
// Stages: input register, one cell per CORDIC step, then five post stages
// (sign fix, multiply, round, reflect, window test); the number of cells
// follows CORDIC_ITERATIONS.
// rst_n is synchronous, clears only the valid flags and config, and sets busy.
// The receiver cannot stall; every beat yields exactly one result beat.
module wall_distance_pose_correction_core #(
  parameter int CORDIC_ITERATIONS = wdpc_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [13:0]        in_distance_mm,
  input  logic signed [15:0] in_pose_x,
  input  logic signed [15:0] in_pose_y,
  input  logic [15:0]        in_heading,
  input  logic               in_correct_x_axis,
  input  logic               in_forced,
  output logic               out_strobe,
  output logic               out_reading_valid,
  output logic               out_pose_updated,
  output logic signed [15:0] out_new_x,
  output logic signed [15:0] out_new_y,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int CW = wdpc_pkg::CW;

  // config registers
  logic [14:0]        wall_r, window_r;
  logic signed [15:0] offx_r, offy_r;
  logic [15:0]        angle_r;
  logic               busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_r   <= 15'd18048;
      window_r <= 15'd1280;
      offx_r   <= '0;
      offy_r   <= '0;
      angle_r  <= '0;
      busy_r   <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        case (wdpc_pkg::cfg_idx_t'(cfg_index))
          wdpc_pkg::CFG_WALL:   wall_r   <= cfg_data[14:0];
          wdpc_pkg::CFG_WINDOW: window_r <= cfg_data[14:0];
          wdpc_pkg::CFG_OFFX:   offx_r   <= cfg_data;
          wdpc_pkg::CFG_OFFY:   offy_r   <= cfg_data;
          wdpc_pkg::CFG_ANGLE:  angle_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;

  // fold an angle into the right half-plane, seed the rotation
  function automatic wdpc_pkg::rot_t seed(input logic [15:0] ang);
    wdpc_pkg::rot_t r;
    logic signed [CW-1:0] z;
    z = CW'($signed({ang, 16'h0}));
    r.x = wdpc_pkg::CORDIC_GAIN;
    r.y = '0;
    r.neg = 1'b0;
    if (z > CW'(64'sd1073741824)) begin
      z = z - CW'(64'sd2147483648);
      r.neg = 1'b1;
    end else if (z < -CW'(64'sd1073741824)) begin
      z = z + CW'(64'sd2147483648);
      r.neg = 1'b1;
    end
    r.z = z;
    return r;
  endfunction

  // input stage: mm to Q10.8 inches, CORDIC seeds
  wdpc_pkg::item_t item_nxt;
  wdpc_pkg::rot_t  rh_nxt, rp_nxt;
  logic [33:0]     prod_mm;

  always_comb begin
    prod_mm         = 34'(in_distance_mm) * 34'(wdpc_pkg::MM_TO_IN) + 34'd32768;
    item_nxt.vld    = start && !busy_r;
    item_nxt.rvalid = (in_distance_mm != wdpc_pkg::INVALID_READING);
    item_nxt.d      = prod_mm[16 +: wdpc_pkg::D_W];
    item_nxt.px     = in_pose_x;
    item_nxt.py     = in_pose_y;
    item_nxt.use_x  = in_correct_x_axis;
    item_nxt.forced = in_forced;
    rh_nxt          = seed(in_heading);
    rp_nxt          = seed(in_heading + angle_r);
  end

  wdpc_pkg::item_t item_c [CORDIC_ITERATIONS+1];
  wdpc_pkg::rot_t  rh_c   [CORDIC_ITERATIONS+1];
  wdpc_pkg::rot_t  rp_c   [CORDIC_ITERATIONS+1];
  wdpc_pkg::item_t item0_r;
  wdpc_pkg::rot_t  rh0_r, rp0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item0_r.vld <= 1'b0;
    end else begin
      item0_r.vld <= item_nxt.vld;
    end
    {item0_r.rvalid, item0_r.d, item0_r.px, item0_r.py, item0_r.use_x, item0_r.forced} <=
      {item_nxt.rvalid, item_nxt.d, item_nxt.px, item_nxt.py, item_nxt.use_x,
       item_nxt.forced};
    rh0_r <= rh_nxt;
    rp0_r <= rp_nxt;
  end

  assign item_c[0] = item0_r;
  assign rh_c[0]   = rh0_r;
  assign rp_c[0]   = rp0_r;

  // CORDIC cell chain
  for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cell
    wdpc_cell #(.SHIFT(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .item_i (item_c[g]),
      .rh_i   (rh_c[g]),
      .rp_i   (rp_c[g]),
      .item_o (item_c[g+1]),
      .rh_o   (rh_c[g+1]),
      .rp_o   (rp_c[g+1])
    );
  end

  wdpc_post u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_i        (item_c[CORDIC_ITERATIONS]),
    .rh_i          (rh_c[CORDIC_ITERATIONS]),
    .rp_i          (rp_c[CORDIC_ITERATIONS]),
    .wall          (wall_r),
    .window        (window_r),
    .offx          (offx_r),
    .offy          (offy_r),
    .strobe        (out_strobe),
    .reading_valid (out_reading_valid),
    .pose_updated  (out_pose_updated),
    .new_x         (out_new_x),
    .new_y         (out_new_y)
  );

endmodule

// ===== rtl/wdpc_cell.sv =====
// One CORDIC micro-rotation for both angles, item carried alongside.
module wdpc_cell #(
  parameter int SHIFT = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  wdpc_pkg::item_t item_i,
  input  wdpc_pkg::rot_t  rh_i,
  input  wdpc_pkg::rot_t  rp_i,
  output wdpc_pkg::item_t item_o,
  output wdpc_pkg::rot_t  rh_o,
  output wdpc_pkg::rot_t  rp_o
);

  localparam logic signed [wdpc_pkg::CW-1:0] ATAN =
    $signed({{(wdpc_pkg::CW-32){1'b0}}, wdpc_pkg::cordic_atan(SHIFT)});

  function automatic wdpc_pkg::rot_t step(input wdpc_pkg::rot_t r);
    wdpc_pkg::rot_t o;
    o = r;
    if (!r.z[wdpc_pkg::CW-1]) begin
      o.x = r.x - (r.y >>> SHIFT);
      o.y = r.y + (r.x >>> SHIFT);
      o.z = r.z - ATAN;
    end else begin
      o.x = r.x + (r.y >>> SHIFT);
      o.y = r.y - (r.x >>> SHIFT);
      o.z = r.z + ATAN;
    end
    return o;
  endfunction

  wdpc_pkg::item_t item_r;
  wdpc_pkg::rot_t  rh_r, rp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else begin
      item_r.vld <= item_i.vld;
    end
    item_r.rvalid <= item_i.rvalid;
    item_r.d      <= item_i.d;
    item_r.px     <= item_i.px;
    item_r.py     <= item_i.py;
    item_r.use_x  <= item_i.use_x;
    item_r.forced <= item_i.forced;
    rh_r <= step(rh_i);
    rp_r <= step(rp_i);
  end

  assign item_o = item_r;
  assign rh_o   = rh_r;
  assign rp_o   = rp_r;

endmodule

// ===== rtl/wdpc_post.sv =====
// Sign fix, offset rotation, projection, wall reflection and window test.
module wdpc_post (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wdpc_pkg::item_t        item_i,
  input  wdpc_pkg::rot_t         rh_i,
  input  wdpc_pkg::rot_t         rp_i,
  input  logic [14:0]            wall,
  input  logic [14:0]            window,
  input  logic signed [15:0]     offx,
  input  logic signed [15:0]     offy,
  output logic                   strobe,
  output logic                   reading_valid,
  output logic                   pose_updated,
  output logic signed [15:0]     new_x,
  output logic signed [15:0]     new_y
);

  localparam int CW  = wdpc_pkg::CW;
  localparam int V_W = wdpc_pkg::V_W;
  localparam int PW  = CW + 16;        // offset products
  localparam int QW  = CW + wdpc_pkg::D_W + 1;  // reading products

  // P1: undo the half-turn fold
  wdpc_pkg::item_t i1_r, i1_nxt;
  logic signed [CW-1:0] sh_r, ch_r, sel_r;
  logic signed [CW-1:0] sh_nxt, ch_nxt, sel_nxt;

  always_comb begin
    i1_nxt  = item_i;
    sh_nxt  = rh_i.neg ? -rh_i.y : rh_i.y;
    ch_nxt  = rh_i.neg ? -rh_i.x : rh_i.x;
    if (item_i.use_x) begin
      sel_nxt = rp_i.neg ? -rp_i.y : rp_i.y;
    end else begin
      sel_nxt = rp_i.neg ? -rp_i.x : rp_i.x;
    end
  end

  // P2: products
  wdpc_pkg::item_t i2_r;
  logic signed [PW-1:0] oxsh_r, oych_r, oxch_r, oysh_r;
  logic signed [QW-1:0] dsel_r;

  // P3: rounding back to Q16.8 and projection sum
  wdpc_pkg::item_t i3_r;
  logic signed [V_W-1:0] v_r, v_nxt;
  logic signed [PW:0]    offy_s, offx_s;
  logic signed [PW:0]    offy_q, offx_q;
  logic signed [QW-1:0]  d_q;

  always_comb begin
    offy_s = PW'(0) + oxsh_r + oych_r;
    offx_s = PW'(0) + oxch_r - oysh_r;
    offy_q = (offy_s + (PW+1)'(1 << 29)) >>> 30;
    offx_q = (offx_s + (PW+1)'(1 << 29)) >>> 30;
    d_q    = (dsel_r + QW'(1 << 29)) >>> 30;
    if (i2_r.use_x) begin
      v_nxt = d_q[V_W-1:0] + offx_q[V_W-1:0];
    end else begin
      v_nxt = d_q[V_W-1:0] - offy_q[V_W-1:0];
    end
  end

  // P4: reflect against the wall; zero counts as positive
  wdpc_pkg::item_t i4_r;
  logic signed [V_W:0] vr_r, vr_nxt;
  logic signed [V_W:0] wall_s;

  always_comb begin
    wall_s = $signed({{(V_W-14){1'b0}}, wall});
    vr_nxt = (v_r[V_W-1] ? -wall_s : wall_s) - {v_r[V_W-1], v_r};
  end

  // P5: window test and write-back
  logic signed [V_W+1:0] diff;
  logic        [V_W+1:0] adiff;
  logic signed [15:0]    cur, sat;
  logic                  upd;

  always_comb begin
    cur   = i4_r.use_x ? i4_r.px : i4_r.py;
    diff  = {vr_r[V_W], vr_r} - (V_W+2)'(cur);
    adiff = diff[V_W+1] ? $unsigned(-diff) : $unsigned(diff);
    upd   = i4_r.rvalid && (adiff < (V_W+2)'(window) || i4_r.forced);
    if (vr_r > (V_W+1)'(32767)) begin
      sat = 16'sh7FFF;
    end else if (vr_r < -(V_W+1)'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = vr_r[15:0];
    end
  end

  logic               strobe_r, valid_r, upd_r;
  logic signed [15:0] nx_r, ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i1_r.vld <= 1'b0;
      i2_r.vld <= 1'b0;
      i3_r.vld <= 1'b0;
      i4_r.vld <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      i1_r.vld <= i1_nxt.vld;
      i2_r.vld <= i1_r.vld;
      i3_r.vld <= i2_r.vld;
      i4_r.vld <= i3_r.vld;
      strobe_r <= i4_r.vld;
    end
    {i1_r.rvalid, i1_r.d, i1_r.px, i1_r.py, i1_r.use_x, i1_r.forced} <=
      {i1_nxt.rvalid, i1_nxt.d, i1_nxt.px, i1_nxt.py, i1_nxt.use_x, i1_nxt.forced};
    {i2_r.rvalid, i2_r.d, i2_r.px, i2_r.py, i2_r.use_x, i2_r.forced} <=
      {i1_r.rvalid, i1_r.d, i1_r.px, i1_r.py, i1_r.use_x, i1_r.forced};
    {i3_r.rvalid, i3_r.d, i3_r.px, i3_r.py, i3_r.use_x, i3_r.forced} <=
      {i2_r.rvalid, i2_r.d, i2_r.px, i2_r.py, i2_r.use_x, i2_r.forced};
    {i4_r.rvalid, i4_r.d, i4_r.px, i4_r.py, i4_r.use_x, i4_r.forced} <=
      {i3_r.rvalid, i3_r.d, i3_r.px, i3_r.py, i3_r.use_x, i3_r.forced};
    sh_r   <= sh_nxt;
    ch_r   <= ch_nxt;
    sel_r  <= sel_nxt;
    oxsh_r <= PW'(offx) * PW'(sh_r);
    oych_r <= PW'(offy) * PW'(ch_r);
    oxch_r <= PW'(offx) * PW'(ch_r);
    oysh_r <= PW'(offy) * PW'(sh_r);
    dsel_r <= $signed(QW'(i1_r.d)) * QW'(sel_r);
    v_r    <= v_nxt;
    vr_r   <= vr_nxt;
    valid_r <= i4_r.rvalid;
    upd_r   <= upd;
    nx_r    <= (upd && i4_r.use_x) ? sat : i4_r.px;
    ny_r    <= (upd && !i4_r.use_x) ? sat : i4_r.py;
  end

  assign strobe        = strobe_r;
  assign reading_valid = valid_r;
  assign pose_updated  = upd_r;
  assign new_x         = nx_r;
  assign new_y         = ny_r;

endmodule

// ===== rtl/wdpc_checker.sv =====
`include "assert_macros.svh"
module wdpc_checker #(
  parameter int LAT = 22
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [15:0] in_pose_x,
  input logic signed [15:0] in_pose_y,
  input logic               out_strobe,
  input logic               out_reading_valid,
  input logic               out_pose_updated,
  input logic signed [15:0] out_new_x,
  input logic signed [15:0] out_new_y
);

  `ASSERT_CLK(a_beat_out, $past(start && !busy, LAT) |-> out_strobe, "result beat missing")
  `ASSERT_CLK(a_beat_in, out_strobe |-> $past(start && !busy, LAT), "result beat out of step")
  `ASSERT_CLK(a_upd_needs_valid, out_strobe && !out_reading_valid |-> !out_pose_updated,
              "update on invalid reading")
  `ASSERT_CLK(a_hold_pose, out_strobe && !out_pose_updated |->
              out_new_x == $past(in_pose_x, LAT) && out_new_y == $past(in_pose_y, LAT),
              "pose changed without update")
  `ASSERT_ALWAYS(a_busy_reset, !rst_n |=> busy, "busy low after reset")

endmodule

bind wall_distance_pose_correction_core wdpc_checker #(.LAT(CORDIC_ITERATIONS + 6)) u_chk (.*);

// ===== tb/wall_distance_pose_correction_core_test.sv =====
module wall_distance_pose_correction_core_test;

  // Pipeline depth per the RTL header; used for the quiet time before a
  // register write and at the end of the run.
  localparam int ITERS   = wdpc_pkg::CORDIC_ITERATIONS_DEF;
  localparam int LATENCY = ITERS + 6;
  localparam int QUIET   = LATENCY + 8;
  // Watchdog: well above the longest legal quiet spell, a drawn gap or the
  // drain, quiet time and register writes between phases.
  localparam int STALL_LIMIT = 4000;

  // Wall correction predictor plus the store of expected result beats.
  class pose_fix_board;
    typedef struct {
      logic               rvalid;
      logic               upd;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
    } fix_t;

    longint atan_turn[24] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};

    longint   wall, window, offx, offy;
    bit [15:0] mount_ang;
    fix_t     pending[$];
    int       fails;

    function new();
      wall = 18048; window = 1280; offx = 0; offy = 0; mount_ang = 0;
      fails = 0;
    endfunction

    function void write_reg(wdpc_pkg::cfg_idx_t idx, logic [15:0] v);
      case (idx)
        wdpc_pkg::CFG_WALL:   wall = v[14:0];
        wdpc_pkg::CFG_WINDOW: window = v[14:0];
        wdpc_pkg::CFG_OFFX:   offx = $signed(v);
        wdpc_pkg::CFG_OFFY:   offy = $signed(v);
        wdpc_pkg::CFG_ANGLE:  mount_ang = v;
        default: ;
      endcase
    endfunction

    function void sincos(bit [15:0] ang, output longint s, output longint c);
      longint x, y, z, t;
      bit flip;
      x = 652032874; y = 0; flip = 0;
      z = longint'($signed({ang, 16'h0000}));
      if (z > (64'sd1 <<< 30)) begin
        z -= (64'sd1 <<< 31); flip = 1;
      end else if (z < -(64'sd1 <<< 30)) begin
        z += (64'sd1 <<< 31); flip = 1;
      end
      for (int i = 0; i < ITERS && i < 24; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i); y = y + (x >>> i); z -= atan_turn[i];
        end else begin
          t = x + (y >>> i); y = y - (x >>> i); z += atan_turn[i];
        end
        x = t;
      end
      if (flip) begin
        x = -x; y = -y;
      end
      s = y; c = x;
    endfunction

    function longint q30(longint v);
      return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // Reflected wall coordinate at full precision.
    function longint reflect(logic [13:0] mm, bit [15:0] head, bit use_x);
      longint d, sh, ch, sp, cp, v;
      d = (longint'(mm) * 660521 + 32768) >>> 16;
      sincos(head, sh, ch);
      sincos(head + mount_ang, sp, cp);
      if (use_x) v = q30(d * sp) + q30(offx * ch - offy * sh);
      else       v = q30(d * cp) - q30(offx * sh + offy * ch);
      return (v >= 0 ? wall : -wall) - v;
    endfunction

    function longint clip16(longint v);
      return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function void note(logic [13:0] mm, logic signed [15:0] px,
                       logic signed [15:0] py, logic [15:0] head,
                       logic use_x, logic frc);
      fix_t   e;
      longint v, diff;
      e.rvalid = 0; e.upd = 0; e.nx = px; e.ny = py;
      if (mm != wdpc_pkg::INVALID_READING) begin
        e.rvalid = 1;
        v = reflect(mm, head, use_x);
        diff = v - (use_x ? longint'(px) : longint'(py));
        if (diff < 0) diff = -diff;
        if (diff < window || frc) begin
          e.upd = 1;
          if (use_x) e.nx = clip16(v);
          else       e.ny = clip16(v);
        end
      end
      pending.push_back(e);
    endfunction

    function void check(logic rv, logic upd, logic signed [15:0] nx,
                        logic signed [15:0] ny);
      fix_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result beat: valid %b upd %b x %h y %h",
                 $time, rv, upd, nx, ny);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (rv !== e.rvalid) begin
        $display("%0t reading_valid exp %b got %b", $time, e.rvalid, rv); fails++;
      end
      if (upd !== e.upd) begin
        $display("%0t pose_updated exp %b got %b", $time, e.upd, upd); fails++;
      end
      if (nx !== e.nx) begin
        $display("%0t new_x exp %h got %h", $time, e.nx, nx); fails++;
      end
      if (ny !== e.ny) begin
        $display("%0t new_y exp %h got %h", $time, e.ny, ny); fails++;
      end
    endfunction
  endclass

  logic               clk, rst_n, start, busy;
  logic [13:0]        in_distance_mm;
  logic signed [15:0] in_pose_x, in_pose_y;
  logic [15:0]        in_heading;
  logic               in_correct_x_axis, in_forced;
  logic               out_strobe, out_reading_valid, out_pose_updated;
  logic signed [15:0] out_new_x, out_new_y;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  pose_fix_board board = new();
  int  idle_cycles = 0;
  bit  burst;

  wall_distance_pose_correction_core u_top (.*);

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Monitor: values seen at the edge are the pre-edge ones, so ordering
  // against the driver's nonblocking updates does not matter.
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      board.note(in_distance_mm, in_pose_x, in_pose_y, in_heading,
                 in_correct_x_axis, in_forced);
    if (rst_n && out_strobe)
      board.check(out_reading_valid, out_pose_updated, out_new_x, out_new_y);
  end

  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_strobe)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // One beat. Called just after a rising edge; start is only lowered when a
  // gap is drawn, so back-to-back beats keep start high.
  task automatic send_beat(logic [13:0] mm, logic [15:0] px, logic [15:0] py,
                           logic [15:0] head, logic use_x, logic frc);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_distance_mm <= mm; in_pose_x <= px; in_pose_y <= py;
    in_heading <= head; in_correct_x_axis <= use_x; in_forced <= frc;
    do @(posedge clk); while (busy);
  endtask

  // Random beat; when near is set the chosen coordinate sits close to the
  // reflected wall value so the window test goes both ways.
  task automatic send_random(bit near);
    logic [13:0] mm;
    logic [15:0] px, py, head;
    logic        use_x, frc;
    longint      v, spread;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 5)       mm = wdpc_pkg::INVALID_READING;
    else if (r < 20) mm = $urandom_range(0, 16383);
    else             mm = $urandom_range(0, 4000);
    px = $urandom; py = $urandom; head = $urandom;
    use_x = $urandom_range(0, 1);
    frc = ($urandom_range(0, 3) == 0);
    if (near && mm != wdpc_pkg::INVALID_READING) begin
      v = board.reflect(mm, head, use_x);
      spread = board.window + 2;
      v = board.clip16(v + longint'($urandom_range(0, 2 * spread)) - spread);
      if (use_x) px = v;
      else       py = v;
    end
    send_beat(mm, px, py, head, use_x, frc);
  endtask

  // Register writes happen only with the pipe drained and quiet.
  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic write_cfg(wdpc_pkg::cfg_idx_t idx, logic [15:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    board.write_reg(idx, v);
    @(posedge clk);
  endtask

  initial begin
    rst_n <= 1'b0; start <= 1'b0; cfg_we <= 1'b0; cfg_index <= '0;
    cfg_data <= '0; in_distance_mm <= '0; in_pose_x <= '0; in_pose_y <= '0;
    in_heading <= '0; in_correct_x_axis <= 1'b0; in_forced <= 1'b0;
    burst = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, invalid code, readings above it, quadrant
    // headings, both axes, forced and unforced.
    send_beat(14'd0,     16'h0000, 16'h0000, 16'h0000, 1, 0);
    send_beat(wdpc_pkg::INVALID_READING, 16'h1234, 16'hEDCB, 16'h4000, 1, 1);
    send_beat(wdpc_pkg::INVALID_READING, 16'h8000, 16'h7FFF, 16'hFFFF, 0, 0);
    send_beat(14'd10000, 16'h7FFF, 16'h8000, 16'h0000, 0, 1);
    send_beat(14'd16383, 16'h8000, 16'h7FFF, 16'h4000, 1, 1);
    send_beat(14'd16383, 16'h7FFF, 16'h8000, 16'h8000, 0, 1);
    send_beat(14'd1000,  16'h0000, 16'h0000, 16'hC000, 1, 0);
    send_beat(14'd1000,  16'h0000, 16'h0000, 16'hFFFF, 0, 0);
    send_beat(14'd0,     16'h4680, 16'h4680, 16'h8000, 0, 0);
    send_beat(14'd0,     16'h4680, 16'h4680, 16'h4000, 1, 0);
    send_beat(14'd9998,  16'hFFFF, 16'h0001, 16'h2000, 1, 1);
    send_beat(14'd1,     16'h0001, 16'hFFFF, 16'h6000, 0, 1);
    send_beat(14'd4571,  16'hB980, 16'h4680, 16'h0000, 0, 0);
    send_beat(14'd4571,  16'h0000, 16'h0000, 16'h8000, 0, 0);
    for (int i = 0; i < 6; i++) send_random(1);

    // Phases of register settings; extremes first, then nominal, then random ones.
    for (int ph = 0; ph < 9; ph++) begin
      drain();   // also the pause until every expected beat is back
      case (ph)
        0: begin
          write_cfg(wdpc_pkg::CFG_WALL, 16'h0000);
          write_cfg(wdpc_pkg::CFG_WINDOW, 16'h0000);
          write_cfg(wdpc_pkg::CFG_OFFX, 16'h8000);
          write_cfg(wdpc_pkg::CFG_OFFY, 16'h8000);
          write_cfg(wdpc_pkg::CFG_ANGLE, 16'h0000);
        end
        1: begin
          write_cfg(wdpc_pkg::CFG_WALL, 16'hFFFF);
          write_cfg(wdpc_pkg::CFG_WINDOW, 16'hFFFF);
          write_cfg(wdpc_pkg::CFG_OFFX, 16'h7FFF);
          write_cfg(wdpc_pkg::CFG_OFFY, 16'h7FFF);
          write_cfg(wdpc_pkg::CFG_ANGLE, 16'hFFFF);
        end
        2: begin
          write_cfg(wdpc_pkg::CFG_WALL, 16'd18048);
          write_cfg(wdpc_pkg::CFG_WINDOW, 16'd1280);
          write_cfg(wdpc_pkg::CFG_OFFX, 16'h0600);
          write_cfg(wdpc_pkg::CFG_OFFY, 16'hFC00);
          write_cfg(wdpc_pkg::CFG_ANGLE, 16'h4000);
          // indexes past the last register are ignored
          write_cfg(wdpc_pkg::cfg_idx_t'(3'd5), $urandom);
          write_cfg(wdpc_pkg::cfg_idx_t'(3'd7), $urandom);
        end
        default: begin
          write_cfg(wdpc_pkg::CFG_WALL, $urandom);
          write_cfg(wdpc_pkg::CFG_WINDOW, $urandom);
          write_cfg(wdpc_pkg::CFG_OFFX,
                    $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2047));
          write_cfg(wdpc_pkg::CFG_OFFY, $urandom);
          write_cfg(wdpc_pkg::CFG_ANGLE, $urandom);
          write_cfg(wdpc_pkg::cfg_idx_t'($urandom_range(5, 7)), $urandom);
        end
      endcase
      cfg_we <= 1'b0;
      @(posedge clk);
      for (int n = 0; n < 120; n++) begin
        if (n % 20 == 0) burst = (ph == 3) || ($urandom_range(0, 3) == 0);
        send_random($urandom_range(0, 1));
      end
    end

    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
    if (board.fails == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
